// ===== rtl/core/hap_pkg.sv =====
// ----------------------------------------------------------------------------
// hap_pkg
// Shared types, character codes and sizes of the authorization parameter
// list parser.
// ----------------------------------------------------------------------------
package hap_pkg;

   // held whitespace store
   localparam int WS_DEPTH = 16;
   localparam int WS_AW    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
   localparam int WS_CW    = $clog2(WS_DEPTH + 1);

   // characters
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   // whitespace codes kept in the store
   localparam logic [1:0] WS_SPACE = 2'd0;
   localparam logic [1:0] WS_TAB   = 2'd1;
   localparam logic [1:0] WS_CR    = 2'd2;
   localparam logic [1:0] WS_LF    = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   typedef enum logic [2:0] {
      MODE_SKIP  = 3'd0,
      MODE_KEY   = 3'd1,
      MODE_VPRE  = 3'd2,
      MODE_QUOTE = 3'd3,
      MODE_ESC   = 3'd4,
      MODE_AFTER = 3'd5,
      MODE_TOKEN = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_RELEASE = 2'd1,
      ST_BYTE    = 2'd2,
      ST_END     = 2'd3
   } seq_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_rel;
      logic load_byte;
      logic load_end;
      logic last;
      logic rel_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic dec_rel;
      logic dec_byte;
      logic dec_end;
      logic plan_end;
      logic rel_last;
   } stat_type;

   function automatic logic [7:0] ws_char(input logic [1:0] code);
      logic [7:0] ch;
      case (code)
         WS_SPACE: ch = CH_SPACE;
         WS_TAB:   ch = CH_TAB;
         WS_CR:    ch = CH_CR;
         WS_LF:    ch = CH_LF;
         default:  ch = CH_SPACE;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/core/hap_ctrl.sv =====
// ----------------------------------------------------------------------------
// hap_ctrl
// Sequencer of the parser: takes a byte, then steps the datapath through the
// beats it causes (held whitespace, the byte itself, the pair end).
// ----------------------------------------------------------------------------
module hap_ctrl
   import hap_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   seq_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.out_free) begin
               if (stat.dec_rel) begin
                  state_in = ST_RELEASE;
               end else if (stat.dec_byte && stat.dec_end) begin
                  state_in = ST_END;
               end
            end
         end
         ST_RELEASE: begin
            if (stat.out_free && stat.rel_last) begin
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (stat.out_free) begin
               state_in = stat.plan_end ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.accept = 1'b1;
               // a single beat goes straight to the output register
               if (!stat.dec_rel && stat.dec_byte) begin
                  cmd.load_byte = 1'b1;
                  cmd.last      = !stat.dec_end;
               end else if (!stat.dec_rel && stat.dec_end) begin
                  cmd.load_end = 1'b1;
                  cmd.last     = 1'b1;
               end
            end
         end
         ST_RELEASE: begin
            if (stat.out_free) begin
               cmd.load_rel = 1'b1;
               cmd.rel_step = 1'b1;
            end
         end
         ST_BYTE: begin
            if (stat.out_free) begin
               cmd.load_byte = 1'b1;
               cmd.last      = !stat.plan_end;
            end
         end
         ST_END: begin
            if (stat.out_free) begin
               cmd.load_end = 1'b1;
               cmd.last     = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/hap_dp.sv =====
// ----------------------------------------------------------------------------
// hap_dp
// Parser datapath: mode and field registers, byte decode, held whitespace
// store, beat plan and the output register.
// ----------------------------------------------------------------------------
module hap_dp
   import hap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   input  cmd_type    cmd,
   output stat_type   stat,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_ws_overflow
);

   // parse state
   mode_type         mode_ff, mode_in;
   logic             ks_ff, ks_in;
   logic             fs_ff, fs_in;
   logic [WS_CW-1:0] hc_ff, hc_in;
   logic             df_ff, df_in;

   // decode results for the offered byte
   logic [WS_CW-1:0] dec_rel;
   logic             dec_byte;
   logic [1:0]       dec_kind;
   logic             dec_end;
   logic             dec_eovf;
   logic             push;
   logic [1:0]       push_code;

   // beat plan of the accepted byte
   logic [WS_CW-1:0] rel_cnt_ff;
   logic [7:0]       byte_ff;
   logic [1:0]       kind_ff;
   logic             end_ff;
   logic             eovf_ff;

   // held whitespace store
   logic [1:0]       ws_mem [WS_DEPTH];
   logic [WS_AW-1:0] idx_ff, idx_in;
   logic [1:0]       rd_ff;
   logic             rel_last;

   // output register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_kind_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic             rsp_ovf_ff;

   // byte decode
   logic             sp_tab;
   logic             is_ws;
   logic [1:0]       ws_code;
   logic             field;
   logic             fkey;
   logic             close_now;
   logic             gate;
   logic [WS_CW-1:0] lim;

   always_comb begin
      sp_tab = (req_in_byte == CH_SPACE) || (req_in_byte == CH_TAB);
      is_ws  = 1'b1;
      case (req_in_byte)
         CH_SPACE: ws_code = WS_SPACE;
         CH_TAB:   ws_code = WS_TAB;
         CH_CR:    ws_code = WS_CR;
         CH_LF:    ws_code = WS_LF;
         default: begin
            ws_code = WS_SPACE;
            is_ws   = 1'b0;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      ks_in     = ks_ff;
      fs_in     = fs_ff;
      hc_in     = hc_ff;
      df_in     = df_ff;
      dec_rel   = '0;
      dec_byte  = 1'b0;
      dec_kind  = KIND_KEY;
      dec_end   = 1'b0;
      dec_eovf  = 1'b0;
      push      = 1'b0;
      push_code = ws_code;
      field     = 1'b0;
      fkey      = 1'b0;
      close_now = 1'b0;
      gate      = 1'b0;
      lim       = '0;

      // mode step
      case (mode_ff)
         MODE_KEY: begin
            fkey = 1'b1;
            if (req_in_byte == CH_EQ) begin
               hc_in   = '0;
               fs_in   = 1'b0;
               mode_in = MODE_VPRE;
            end else if (req_in_byte == CH_COMMA) begin
               close_now = 1'b1;
            end else begin
               field = 1'b1;
            end
         end
         MODE_VPRE: begin
            if (sp_tab) begin
               mode_in = MODE_VPRE;
            end else if (req_in_byte == CH_QUOTE) begin
               mode_in = MODE_QUOTE;
            end else begin
               mode_in = MODE_TOKEN;
               if (req_in_byte == CH_COMMA) begin
                  close_now = 1'b1;
               end else begin
                  field = 1'b1;
               end
            end
         end
         MODE_QUOTE: begin
            if (req_in_byte == CH_QUOTE) begin
               mode_in = MODE_AFTER;
            end else if (req_in_byte == CH_BSLASH && !req_is_last) begin
               mode_in = MODE_ESC;
            end else if (ks_ff) begin
               dec_byte = 1'b1;
               dec_kind = KIND_VALUE;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_QUOTE;
            if (ks_ff) begin
               dec_byte = 1'b1;
               dec_kind = KIND_VALUE;
            end
         end
         MODE_AFTER: begin
            if (req_in_byte == CH_COMMA) begin
               close_now = 1'b1;
            end
         end
         MODE_TOKEN: begin
            if (req_in_byte == CH_COMMA) begin
               close_now = 1'b1;
            end else begin
               field = 1'b1;
            end
         end
         default: begin
            // separators before a key; anything else opens a key
            mode_in = MODE_SKIP;
            if (!(sp_tab || req_in_byte == CH_COMMA)) begin
               mode_in = MODE_KEY;
               ks_in   = 1'b0;
               fs_in   = 1'b0;
               hc_in   = '0;
               df_in   = 1'b0;
               fkey    = 1'b1;
               if (req_in_byte == CH_EQ) begin
                  mode_in = MODE_VPRE;
               end else begin
                  field = 1'b1;
               end
            end
         end
      endcase

      // key or token byte: hold inner whitespace, release it before text
      if (field) begin
         gate = fkey || ks_in;
         if (is_ws) begin
            if (fs_in) begin
               if (hc_in < WS_CW'(WS_DEPTH)) begin
                  push  = 1'b1;
                  hc_in = hc_in + WS_CW'(1);
               end else begin
                  df_in = 1'b1;
               end
            end
         end else begin
            lim = hc_in;
            // full store on the final byte keeps one entry back
            if (gate && req_is_last && hc_in >= WS_CW'(WS_DEPTH)) begin
               lim   = WS_CW'(WS_DEPTH - 1);
               df_in = 1'b1;
            end
            if (gate) begin
               dec_rel  = lim;
               dec_byte = 1'b1;
               dec_kind = fkey ? KIND_KEY : KIND_VALUE;
            end
            hc_in = '0;
            fs_in = 1'b1;
            if (fkey) begin
               ks_in = 1'b1;
            end
         end
      end

      // pair close on a comma or at the end of text
      if (close_now || req_is_last) begin
         if (ks_in) begin
            dec_end  = 1'b1;
            dec_eovf = df_in;
         end
         ks_in   = 1'b0;
         fs_in   = 1'b0;
         hc_in   = '0;
         df_in   = 1'b0;
         mode_in = MODE_SKIP;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
         ks_ff   <= 1'b0;
         fs_ff   <= 1'b0;
         hc_ff   <= '0;
         df_ff   <= 1'b0;
      end else if (cmd.accept) begin
         mode_ff <= mode_in;
         ks_ff   <= ks_in;
         fs_ff   <= fs_in;
         hc_ff   <= hc_in;
         df_ff   <= df_in;
      end
   end

   // beat plan
   always_ff @(posedge clock) begin
      if (reset) begin
         rel_cnt_ff <= '0;
         end_ff     <= 1'b0;
      end else if (cmd.accept) begin
         rel_cnt_ff <= dec_rel;
         end_ff     <= dec_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_in_byte;
         kind_ff <= dec_kind;
         eovf_ff <= dec_eovf;
      end
   end

   // release index
   assign rel_last = (WS_CW'(idx_ff) + WS_CW'(1)) == rel_cnt_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.rel_step) begin
         idx_in = rel_last ? '0 : idx_ff + WS_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // whitespace store, registered read at the next index
   always_ff @(posedge clock) begin
      if (cmd.accept && push) begin
         ws_mem[hc_ff[WS_AW-1:0]] <= push_code;
      end
      rd_ff <= ws_mem[idx_in];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rel || cmd.load_byte || cmd.load_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rel) begin
         rsp_kind_ff <= kind_ff;
         rsp_byte_ff <= ws_char(rd_ff);
         rsp_last_ff <= 1'b0;
         rsp_ovf_ff  <= 1'b0;
      end else if (cmd.load_byte) begin
         rsp_kind_ff <= cmd.accept ? dec_kind : kind_ff;
         rsp_byte_ff <= cmd.accept ? req_in_byte : byte_ff;
         rsp_last_ff <= cmd.last;
         rsp_ovf_ff  <= 1'b0;
      end else if (cmd.load_end) begin
         rsp_kind_ff <= KIND_END;
         rsp_byte_ff <= 8'h00;
         rsp_last_ff <= cmd.last;
         rsp_ovf_ff  <= cmd.accept ? dec_eovf : eovf_ff;
      end
   end

   // status
   always_comb begin
      stat.out_free = !rsp_valid_ff || !rsp_stall;
      stat.dec_rel  = (dec_rel != '0);
      stat.dec_byte = dec_byte;
      stat.dec_end  = dec_end;
      stat.plan_end = end_ff;
      stat.rel_last = rel_last;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_ws_overflow = rsp_ovf_ff;

endmodule

// ===== rtl/core/http_auth_param_parser_core.sv =====
// ----------------------------------------------------------------------------
// http_auth_param_parser_core
// Byte-serial parser of an HTTP authorization parameter list.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one text byte per beat (req_in_byte), req_is_last on the
//   final byte. A beat is taken when req_valid is high and req_stall low.
//   rsp_ channel: key bytes, value bytes and pair-end beats (rsp_kind),
//   rsp_run_last on the last beat caused by an input byte, rsp_ws_overflow
//   on a pair end whose held whitespace overflowed.
//   Latency: a beat loaded as its byte is taken is presented the next cycle;
//   a byte that first releases held whitespace has its first beat loaded
//   in the release state, which starts after the byte is taken.
//   A new byte is taken only in the idle state, once every beat of the last
//   byte (up to WS_DEPTH held whitespace beats, the byte, its pair end) is
//   loaded into the single output register; the store is read one entry
//   per cycle while the output register is free.
//   Reset returns the parser to skipping separators before a key with an
//   empty output register; the whitespace store needs no clearing.
//   While a presented beat is stalled by rsp_stall, the output register
//   holds it and req_stall is raised, so no byte is taken.
// ----------------------------------------------------------------------------
module http_auth_param_parser_core
   import hap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_ws_overflow
);

   cmd_type  cmd;
   stat_type stat;

   hap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   hap_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .req_is_last     (req_is_last),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_ws_overflow (rsp_ws_overflow)
   );

endmodule
